/* rtl/lru_page_replacement_top_assert.svh */
// Assertion macros shared by the replacement block.
// Each macro checks a property on the rising edge of clk and is quiet while rst is high.
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lru_pr_pkg.sv */
`default_nettype none

package lru_pr_pkg;

  // Default values for the top-level parameters.
  localparam int MAX_FRAME_COUNT_DEF  = 16;
  localparam int PAGE_NUMBER_BITS_DEF = 10;

  // Widths of the fields carried on the ports.
  localparam int FRAMES_CFG_W = 5;
  localparam int PAGE_FIELD_W = 10;
  localparam int SLOT_FIELD_W = 4;
  localparam int FAULT_W      = 16;

  localparam logic [FRAMES_CFG_W-1:0] FRAMES_CFG_RESET = FRAMES_CFG_W'(4);

  typedef struct packed {
    logic [PAGE_FIELD_W-1:0] page_number;
    logic                    last_reference;
  } lru_in_t;

  typedef struct packed {
    logic                    page_fault;
    logic [SLOT_FIELD_W-1:0] frame_slot;
    logic                    evicted_valid;
    logic [PAGE_FIELD_W-1:0] evicted_page;
    logic [FAULT_W-1:0]      fault_total;
    logic                    sequence_end;
  } lru_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lru_state_t;

endpackage

`default_nettype wire

/* rtl/lru_page_replacement_top.sv */
// Exact LRU page replacement over a set of page frames.
// Input channel: in_valid, in_stall and in_data carry one page reference per transaction.
// A transaction completes on a rising edge where in_valid is high and in_stall is low.
// Output channel: out_valid, out_stall and out_data carry one result per reference: hit or
// fault, the frame that now holds the page, any evicted page, the saturating fault count and
// an echo of the end-of-sequence flag.
// Configuration: cfg_write and cfg_data set the number of frames in use (0 acts as 1, values
// above the frame capacity act as the capacity). Write it only while the block is idle.
// One compare unit walks the active frames, one per cycle, behind a small sequencer. Each
// reference passes through the idle/accept state, a scan of the active frames and the update
// state, and a new reference is accepted only once the block is back in the idle state.
// The result sits in an output register. A new reference is accepted while it waits; the
// update of that next reference holds until the receiver has taken the previous result.
// A stalled result does not change.
// Reset (synchronous, active high) empties all frames, clears recency ranks and the fault
// count, sets the frame count to 4 and drops out_valid. The page store has no reset.
`default_nettype none

`include "lru_page_replacement_top_assert.svh"

module lru_page_replacement_top
  import lru_pr_pkg::*;
#(
  parameter int MAX_FRAME_COUNT  = MAX_FRAME_COUNT_DEF,
  parameter int PAGE_NUMBER_BITS = PAGE_NUMBER_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire lru_in_t                 in_data,
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      lru_out_t                out_data,
  input  wire logic                    cfg_write,
  input  wire logic [FRAMES_CFG_W-1:0] cfg_data
);

  localparam int IDX_W  = (MAX_FRAME_COUNT > 1) ? $clog2(MAX_FRAME_COUNT) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAME_COUNT + 1);
  localparam int CMP_W  = (CNT_W > FRAMES_CFG_W) ? CNT_W : FRAMES_CFG_W;
  localparam int RANK_W = IDX_W;

  // Sequencer state.
  lru_state_t state, state_next;

  // Configuration register.
  logic [FRAMES_CFG_W-1:0] frames_in_use;

  // Frame state. The page store is a memory with a registered read port.
  logic [PAGE_NUMBER_BITS-1:0] frame_page [MAX_FRAME_COUNT];
  logic [PAGE_NUMBER_BITS-1:0] page_rdata;
  logic [MAX_FRAME_COUNT-1:0]  frame_valid;
  logic [RANK_W-1:0]           recency_rank [MAX_FRAME_COUNT];
  logic [FAULT_W-1:0]          fault_counter;
  logic [FAULT_W-1:0]          fault_counter_next;

  // The reference being worked on.
  logic [PAGE_NUMBER_BITS-1:0] page_q;
  logic                        last_q;

  // Scan results.
  logic [IDX_W-1:0]            scan_idx;
  logic                        hit_found;
  logic                        empty_found;
  logic [IDX_W-1:0]            hit_slot;
  logic [IDX_W-1:0]            empty_slot;
  logic [IDX_W-1:0]            lru_slot;
  logic [RANK_W-1:0]           hit_rank;
  logic [RANK_W-1:0]           max_rank;
  logic [PAGE_NUMBER_BITS-1:0] lru_page;

  // Control.
  logic                        accept;
  logic                        scan_last;
  logic                        commit;
  logic [IDX_W-1:0]            rd_addr;

  // Derived values.
  logic [CMP_W-1:0]            cfg_ext;
  logic [CMP_W-1:0]            active_cnt;
  logic [IDX_W-1:0]            last_idx;
  logic                        frame_match;
  logic [IDX_W-1:0]            slot_sel;
  logic                        age_all;
  logic [RANK_W-1:0]           age_limit;
  logic                        evict;
  logic [31:0]                 page_in_wide;
  logic [31:0]                 slot_wide;
  logic [31:0]                 evict_wide;
  logic                        stale_rank;

  // The frame count is clamped to 1..MAX_FRAME_COUNT; the scan stops at the last active frame.
  always_comb begin
    cfg_ext = CMP_W'(frames_in_use);
    if (cfg_ext == '0) begin
      active_cnt = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_FRAME_COUNT)) begin
      active_cnt = CMP_W'(MAX_FRAME_COUNT);
    end else begin
      active_cnt = cfg_ext;
    end
    last_idx = IDX_W'(active_cnt - CMP_W'(1));
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == last_idx) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs. Frame 0 is read while idle so that its page is ready in the first
  // scan cycle; each scan cycle then fetches the frame after the one being compared.
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    scan_last = 1'b0;
    commit    = 1'b0;
    rd_addr   = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ST_SCAN: begin
        scan_last = (scan_idx == last_idx);
        rd_addr   = scan_last ? '0 : IDX_W'(scan_idx + 1'b1);
      end
      ST_UPDATE: begin
        commit = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_CFG_RESET;
    end else if (cfg_write) begin
      frames_in_use <= cfg_data;
    end
  end

  // The shared compare unit: one frame's page and rank per cycle.
  assign frame_match = frame_valid[scan_idx] && (page_rdata == page_q);

  // Slot choice and aging rule for the update.
  always_comb begin
    evict = !hit_found && !empty_found;
    if (hit_found) begin
      slot_sel = hit_slot;
    end else if (empty_found) begin
      slot_sel = empty_slot;
    end else begin
      slot_sel = lru_slot;
    end
    // Filling an empty frame ages every resident frame; otherwise only the younger ones age.
    age_all   = !hit_found && empty_found;
    age_limit = hit_found ? hit_rank : max_rank;
    if (!hit_found && (fault_counter != '1)) begin
      fault_counter_next = fault_counter + 1'b1;
    end else begin
      fault_counter_next = fault_counter;
    end
    page_in_wide = 32'(in_data.page_number);
    slot_wide    = 32'(slot_sel);
    evict_wide   = 32'(lru_page);
  end

  // Page store.
  always_ff @(posedge clk) begin
    page_rdata <= frame_page[rd_addr];
    if (commit && !hit_found) begin
      frame_page[slot_sel] <= page_q;
    end
  end

  // Reference capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      scan_idx    <= '0;
    end else if (accept) begin
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
      scan_idx    <= '0;
    end else if (state == ST_SCAN) begin
      if (frame_match && !hit_found) begin
        hit_found <= 1'b1;
      end
      if (!frame_valid[scan_idx] && !empty_found) begin
        empty_found <= 1'b1;
      end
      if (!scan_last) begin
        scan_idx <= IDX_W'(scan_idx + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_q   <= page_in_wide[PAGE_NUMBER_BITS-1:0];
      last_q   <= in_data.last_reference;
      max_rank <= '0;
      lru_slot <= '0;
    end else if (state == ST_SCAN) begin
      if (frame_match && !hit_found) begin
        hit_slot <= scan_idx;
        hit_rank <= recency_rank[scan_idx];
      end
      if (!frame_valid[scan_idx] && !empty_found) begin
        empty_slot <= scan_idx;
      end
      // Oldest frame: the lowest-numbered one of highest rank, frame 0 if all ranks are zero.
      if ((scan_idx == '0) || (recency_rank[scan_idx] > max_rank)) begin
        max_rank <= recency_rank[scan_idx];
        lru_slot <= scan_idx;
        lru_page <= page_rdata;
      end
    end
  end

  // Frame valid bits, recency ranks and the fault counter change only at the update.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      fault_counter <= '0;
      for (int i = 0; i < MAX_FRAME_COUNT; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (commit) begin
      frame_valid[slot_sel] <= 1'b1;
      fault_counter         <= fault_counter_next;
      for (int i = 0; i < MAX_FRAME_COUNT; i++) begin
        if (IDX_W'(i) == slot_sel) begin
          recency_rank[i] <= '0;
        end else if (frame_valid[i] && (age_all || (recency_rank[i] < age_limit))) begin
          recency_rank[i] <= RANK_W'(recency_rank[i] + 1'b1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data.page_fault    <= !hit_found;
      out_data.frame_slot    <= slot_wide[SLOT_FIELD_W-1:0];
      out_data.evicted_valid <= evict;
      out_data.evicted_page  <= evict ? evict_wide[PAGE_FIELD_W-1:0] : '0;
      out_data.fault_total   <= fault_counter_next;
      out_data.sequence_end  <= last_q;
    end
  end

  // An empty frame must keep a rank of zero, or it would distort the oldest-frame search.
  always_comb begin
    stale_rank = 1'b0;
    for (int i = 0; i < MAX_FRAME_COUNT; i++) begin
      if (!frame_valid[i] && (recency_rank[i] != '0)) begin
        stale_rank = 1'b1;
      end
    end
  end

  `LRU_ASSERT_NEXT(a_fault_only_at_update, !commit, $stable(fault_counter), "fault count moved outside an update")
  `LRU_ASSERT_NOW(a_empty_rank_zero, 1'b1, !stale_rank, "an empty frame holds a nonzero rank")
  `LRU_ASSERT_NEXT(a_fill_by_one, 1'b1, ($countones(frame_valid) >= $past($countones(frame_valid))) && ($countones(frame_valid) <= $past($countones(frame_valid)) + 1), "frame fill changed by more than one")
  `LRU_ASSERT_NOW(a_slot_active, state == ST_UPDATE, slot_sel <= last_idx, "chosen frame lies beyond the active frames")

endmodule

`default_nettype wire

/* tb/tb_lru_page_replacement_top.sv */
`timescale 1ns / 100ps

// Self-checking testbench for the LRU page replacement block.
// Every reference that completes an input transaction is run through a
// behavioral copy of the replacement policy kept in this module. The
// predicted result is queued, and every output transaction is compared
// field by field with the oldest queued result. Stimulus is a short directed
// part, random reference strings with locality and directed stall tests. The run goes
// through several frame counts and several idling patterns on both channels.
// It ends with a short run at one frame, where most references are faults
// that evict the only resident page.
module tb_lru_page_replacement_top;
  import lru_pr_pkg::*;

  localparam int FRAME_CAP     = MAX_FRAME_COUNT_DEF;
  localparam int FAULT_CEILING = (1 << FAULT_W) - 1;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_GUARD   = 2 * FRAME_CAP + 8;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int MAX_REPORTS   = 40;
  localparam int PHASE_ITEMS   = 125;
  localparam int PHASE_COUNT   = 12;
  localparam int SINGLE_ITEMS  = 40;

  // Frame counts used by the random phases, phase 0 in the low five bits.
  // The list holds the extremes, 0 (acts as 1) and 31 (acts as the capacity),
  // and 17, the first value above the capacity.
  localparam logic [5*PHASE_COUNT-1:0] FRAME_SETTINGS = {
    5'd16, 5'd5, 5'd17, 5'd12, 5'd3, 5'd31, 5'd8, 5'd0, 5'd2, 5'd16, 5'd4, 5'd1
  };

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  lru_in_t                 in_data   = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  lru_out_t                out_data;
  logic                    cfg_write = 1'b0;
  logic [FRAMES_CFG_W-1:0] cfg_data  = '0;

  // Predicted contents of the frames. The page store is only read for frames
  // marked valid, so it needs no reset value here.
  logic [PAGE_FIELD_W-1:0] held_page  [FRAME_CAP];
  bit                      held_valid [FRAME_CAP];
  int unsigned             held_rank  [FRAME_CAP];
  int unsigned             fault_tally   = 0;
  logic [FRAMES_CFG_W-1:0] frame_setting = FRAMES_CFG_RESET;

  // Results that the block still owes, oldest first.
  lru_out_t outcome_queue [$];

  int error_count        = 0;
  int cycle_count        = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  // A test asks for a long receiver hold by bumping hold_requests. The
  // receiver process notices the difference and counts the hold down itself.
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  always #5 clk = ~clk;

  lru_page_replacement_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // Out-of-range frame counts are clamped: zero acts as one frame, anything
  // above the capacity acts as the capacity.
  function automatic int active_frames(input logic [FRAMES_CFG_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > FRAME_CAP) return FRAME_CAP;
    return int'(setting);
  endfunction

  // Frame f becomes the most recent one. Valid frames younger than limit age
  // by one step. Frames outside the active range age as well.
  function automatic void make_most_recent(input int f, input int unsigned limit);
    int i;
    for (i = 0; i < FRAME_CAP; i++) begin
      if (i != f && held_valid[i] && held_rank[i] < limit) held_rank[i]++;
    end
    held_rank[f] = 0;
  endfunction

  // Apply one reference to the predicted frame state and return the result
  // that the block has to produce for it.
  function automatic lru_out_t apply_reference(input logic [PAGE_FIELD_W-1:0] page,
                                               input logic is_last);
    int          i;
    int          n;
    int          slot;
    bit          hit;
    bit          found_empty;
    int unsigned oldest;
    lru_out_t    res;

    n           = active_frames(frame_setting);
    slot        = 0;
    hit         = 1'b0;
    found_empty = 1'b0;
    res         = '0;

    // The lowest-numbered matching active frame wins, which settles the case
    // of one page resident in two frames.
    for (i = 0; i < n; i++) begin
      if (!hit && held_valid[i] && held_page[i] == page) begin
        hit  = 1'b1;
        slot = i;
      end
    end

    if (hit) begin
      make_most_recent(slot, held_rank[slot]);
    end else begin
      if (fault_tally < FAULT_CEILING) fault_tally++;
      for (i = 0; i < n; i++) begin
        if (!found_empty && !held_valid[i]) begin
          found_empty = 1'b1;
          slot        = i;
        end
      end
      if (found_empty) begin
        make_most_recent(slot, 32'hFFFF_FFFF);
        held_valid[slot] = 1'b1;
      end else begin
        // Least recently used active frame; on equal ranks the lower
        // frame number is kept.
        oldest = 0;
        slot   = 0;
        for (i = 0; i < n; i++) begin
          if (held_rank[i] > oldest) begin
            oldest = held_rank[i];
            slot   = i;
          end
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = held_page[slot];
        make_most_recent(slot, held_rank[slot]);
      end
      held_page[slot] = page;
    end

    res.page_fault   = !hit;
    res.frame_slot   = SLOT_FIELD_W'(slot);
    res.fault_total  = FAULT_W'(fault_tally);
    res.sequence_end = is_last;
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [FAULT_W-1:0] expected_v,
                                      input logic [FAULT_W-1:0] actual_v);
    if (actual_v !== expected_v) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, field, expected_v, actual_v);
    end
  endfunction

  // Result checker. An output transaction completes on an edge where
  // out_valid is high and out_stall is low. Both are sampled as they stood
  // just before the edge, because every driver updates them with
  // nonblocking assignments.
  always @(posedge clk) begin
    lru_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (outcome_queue.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with none outstanding, expected nothing, actual %p",
                   $time, out_data);
      end else begin
        want = outcome_queue.pop_front();
        check_field("page_fault", want.page_fault, out_data.page_fault);
        check_field("frame_slot", want.frame_slot, out_data.frame_slot);
        check_field("evicted_valid", want.evicted_valid, out_data.evicted_valid);
        check_field("evicted_page", want.evicted_page, out_data.evicted_page);
        check_field("fault_total", want.fault_total, out_data.fault_total);
        check_field("sequence_end", want.sequence_end, out_data.sequence_end);
      end
    end
  end

  // Receiver. It stalls at random at the current rate, except during a
  // requested long hold, when it stalls on every cycle.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic set_idling(input int send_pct, input int stall_pct);
    sender_idle_pct    = send_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // Offer one reference and hold it until the transaction completes. The
  // valid is left high afterwards, so that back-to-back references keep it
  // high without a drop in between. Idle cycles come before the reference.
  task automatic send_reference(input logic [PAGE_FIELD_W-1:0] page, input logic is_last);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{page_number: page, last_reference: is_last};
    do @(posedge clk); while (in_stall !== 1'b0);
    outcome_queue.push_back(apply_reference(page, is_last));
  endtask

  // Stop offering and wait until every outstanding result has come. With
  // one result per reference the block is idle after that.
  task automatic wait_for_outcomes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outcome_queue.size() != 0) @(posedge clk);
  endtask

  // Write the frame count. The caller makes sure that the block is idle.
  task automatic write_frame_count(input logic [FRAMES_CFG_W-1:0] setting);
    cfg_write <= 1'b1;
    cfg_data  <= setting;
    @(posedge clk);
    cfg_write     <= 1'b0;
    frame_setting = setting;
  endtask

  // Reset frame count of four: fill the frames with both page extremes,
  // hit, evict the least recently used page and bring an evicted page back.
  task automatic test_reset_frame_count();
    set_idling(0, 0);
    send_reference(10'd0, 1'b0);
    send_reference(10'd1023, 1'b1);
    send_reference(10'd0, 1'b0);
    send_reference(10'd5, 1'b0);
    send_reference(10'd6, 1'b0);
    send_reference(10'd7, 1'b0);
    send_reference(10'd1023, 1'b0);
    send_reference(10'd7, 1'b1);
  endtask

  // A frame count of zero acts as one frame, where the only frame is always
  // the victim. A count of 31 acts as the full capacity and opens empty
  // frames above the first four.
  task automatic test_frame_count_limits();
    wait_for_outcomes();
    write_frame_count(5'd0);
    send_reference(10'd3, 1'b0);
    send_reference(10'd3, 1'b0);
    send_reference(10'd9, 1'b1);
    wait_for_outcomes();
    write_frame_count(5'd31);
    send_reference(10'd1023, 1'b0);
    send_reference(10'd7, 1'b0);
  endtask

  // With two active frames, pages resident only in frames 3 and 4 miss and
  // get a second copy in the active range. Once the range is widened again,
  // the lower copy of each page must be the hit, and a frame that aged while
  // inactive is hit as usual.
  task automatic test_inactive_frames();
    wait_for_outcomes();
    write_frame_count(5'd2);
    send_reference(10'd1023, 1'b0);
    send_reference(10'd6, 1'b0);
    wait_for_outcomes();
    write_frame_count(5'd17);
    send_reference(10'd1023, 1'b0);
    send_reference(10'd6, 1'b1);
    send_reference(10'd5, 1'b0);
    send_reference(10'd512, 1'b0);
  endtask

  // Random phases. Most traffic consists of reference strings drawn from a
  // small working set near a random base, so that hits, fills and evictions
  // all happen at every frame count. The rest is scattered single references.
  task automatic test_random_references();
    int                      phase;
    int                      sent;
    int                      seq_len;
    int                      working_set;
    int                      k;
    logic [FRAMES_CFG_W-1:0] setting;
    logic [PAGE_FIELD_W-1:0] base;

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_for_outcomes();
      setting = FRAME_SETTINGS[phase*FRAMES_CFG_W +: FRAMES_CFG_W];
      write_frame_count(setting);
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(76, 0);
        2: set_idling(0, 76);
        default: set_idling(28, 28);
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          base        = PAGE_FIELD_W'($urandom_range(0, 1023));
          working_set = $urandom_range(1, active_frames(setting) + 3);
          seq_len     = $urandom_range(4, 30);
          for (k = 0; k < seq_len; k++)
            send_reference(base + PAGE_FIELD_W'($urandom_range(0, working_set - 1)),
                           k == seq_len - 1);
          sent += seq_len;
        end else begin
          send_reference(PAGE_FIELD_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering references back to back, so the output register fills and the
  // block has to stall its input.
  task automatic test_long_receiver_hold();
    int k;
    wait_for_outcomes();
    set_idling(0, 0);
    hold_requests++;
    for (k = 0; k < 40; k++)
      send_reference(PAGE_FIELD_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  // Short bursts, each followed by a pause until every result is back.
  task automatic test_sender_pause();
    int burst;
    int k;
    set_idling(28, 28);
    for (burst = 0; burst < 3; burst++) begin
      for (k = 0; k < 8; k++)
        send_reference(PAGE_FIELD_W'($urandom_range(0, 31)), k == 7);
      wait_for_outcomes();
    end
  endtask

  // With one frame every change of page is a fault that evicts the only
  // resident page, and a repeat of the same page is a hit in frame 0.
  task automatic test_single_frame();
    int                      k;
    logic [PAGE_FIELD_W-1:0] page;
    wait_for_outcomes();
    write_frame_count(5'd1);
    set_idling(0, 0);
    page = '0;
    for (k = 0; k < SINGLE_ITEMS; k++) begin
      if ($urandom_range(0, 3) != 0) page = page ^ PAGE_FIELD_W'($urandom_range(1, 1023));
      send_reference(page, k == SINGLE_ITEMS - 1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_frame_count();
    test_frame_count_limits();
    test_inactive_frames();
    test_random_references();
    test_long_receiver_hold();
    test_sender_pause();
    test_single_frame();

    // Let any stray result show up before the verdict.
    wait_for_outcomes();
    repeat (DRAIN_GUARD) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
